[design/rlcfs_pkg.sv]
// Shared types, codes and helpers for the RGB LED color fade sequencer.
// No dependencies; every other file imports this package.
package rlcfs_pkg;

  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned SEL_W    = 4;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned CFG_AW   = 1;
  localparam int unsigned CFG_DW   = 16;

  localparam logic [DUTY_W-1:0]   DUTY_FULL    = 8'd255;
  localparam logic [DUTY_W-1:0]   DUTY_FLOOR   = 8'd1;
  localparam logic [DUTY_W-1:0]   DUTY_ZERO    = 8'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd255;
  localparam logic [THRESH_W-1:0] THRESH_RST   = 16'd16;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_PWM_PERIOD    = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_STEP_THRESHOLD = 1'd1;

  // request kinds
  localparam logic FUNC_COLOR = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [SEL_W-1:0] {
    MODE_OFF    = 4'd0,
    MODE_RED    = 4'd1,
    MODE_GREEN  = 4'd2,
    MODE_BLUE   = 4'd3,
    MODE_YELLOW = 4'd4,
    MODE_PURPLE = 4'd5,
    MODE_CYAN   = 4'd6,
    MODE_WHITE  = 4'd7,
    MODE_BREATH = 4'd8
  } mode_t;

  typedef enum logic [3:0] {
    PH_R_UP  = 4'd0,
    PH_R_DN  = 4'd1,
    PH_G_UP  = 4'd2,
    PH_G_DN  = 4'd3,
    PH_B_UP  = 4'd4,
    PH_B_DN  = 4'd5,
    PH_RG_UP = 4'd6,
    PH_RG_DN = 4'd7,
    PH_RB_UP = 4'd8,
    PH_RB_DN = 4'd9,
    PH_GB_UP = 4'd10,
    PH_GB_DN = 4'd11
  } phase_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    mode_t              mode;
    phase_t             phase;
    rgb_t               duty;
    logic [TIMER_W-1:0] last_time;
  } fade_state_t;

  typedef struct packed {
    logic               func;
    logic [SEL_W-1:0]   color_sel;
    logic [TIMER_W-1:0] timer_now;
  } item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] pwm_period;
    logic [THRESH_W-1:0] step_threshold;
  } cfg_t;

  typedef struct packed {
    rgb_t                duty;
    logic [PERIOD_W-1:0] period;
    logic                updated;
  } result_t;

  // fixed color table: each channel fully on or off
  function automatic rgb_t color_duty(input logic [2:0] sel);
    rgb_t c;
    c.red   = (sel == 3'd1 || sel == 3'd4 || sel == 3'd5 || sel == 3'd7) ? DUTY_FULL : DUTY_ZERO;
    c.green = (sel == 3'd2 || sel == 3'd4 || sel == 3'd6 || sel == 3'd7) ? DUTY_FULL : DUTY_ZERO;
    c.blue  = (sel == 3'd3 || sel == 3'd5 || sel == 3'd6 || sel == 3'd7) ? DUTY_FULL : DUTY_ZERO;
    return c;
  endfunction

endpackage

[design/rlcfs_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on rlcfs_pkg for field widths.
interface rlcfs_in_if import rlcfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [SEL_W-1:0]   color_sel;
  logic [TIMER_W-1:0] timer_now;

  modport source (output valid, func, color_sel, timer_now, input ready);
  modport sink   (input valid, func, color_sel, timer_now, output ready);
endinterface

interface rlcfs_out_if import rlcfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DUTY_W-1:0]   red_level;
  logic [DUTY_W-1:0]   green_level;
  logic [DUTY_W-1:0]   blue_level;
  logic [PERIOD_W-1:0] period_out;
  logic                updated;

  modport source (output valid, red_level, green_level, blue_level, period_out, updated,
                  input ready);
  modport sink   (input valid, red_level, green_level, blue_level, period_out, updated,
                  output ready);
endinterface

[design/rlcfs_cfg.sv]
// Configuration registers: PWM period and fade step threshold.
// Depends on rlcfs_pkg.
module rlcfs_cfg import rlcfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period     <= PERIOD_RST;
      cfg_r.step_threshold <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PWM_PERIOD:     cfg_r.pwm_period     <= cfg_wdata[PERIOD_W-1:0];
        CFG_STEP_THRESHOLD: cfg_r.step_threshold <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/rlcfs_step.sv]
// Next-state logic for one request: color load, breathing entry, fade step.
// Depends on rlcfs_pkg.
module rlcfs_step import rlcfs_pkg::*; (
  input  fade_state_t         cur,
  input  item_t               item,
  input  logic [THRESH_W-1:0] threshold,
  output fade_state_t         nxt,
  output logic                updated
);

  logic [TIMER_W-1:0] diff;
  rgb_t               d;
  rgb_t               dn;
  phase_t             ph_n;

  assign diff = cur.last_time - item.timer_now;
  assign d    = cur.duty;

  // one step of the twelve-phase fade
  always_comb begin
    dn   = d;
    ph_n = cur.phase;
    case (cur.phase)
      PH_R_UP: begin
        if (d.red < DUTY_FULL) dn.red = d.red + 8'd1;
        else ph_n = PH_R_DN;
      end
      PH_R_DN: begin
        if (d.red > DUTY_FLOOR) dn.red = d.red - 8'd1;
        else begin
          dn.green = DUTY_FLOOR;
          ph_n     = PH_G_UP;
        end
      end
      PH_G_UP: begin
        if (d.green < DUTY_FULL) dn.green = d.green + 8'd1;
        else ph_n = PH_G_DN;
      end
      PH_G_DN: begin
        if (d.green > DUTY_FLOOR) dn.green = d.green - 8'd1;
        else begin
          dn.blue = DUTY_FLOOR;
          ph_n    = PH_B_UP;
        end
      end
      PH_B_UP: begin
        if (d.blue < DUTY_FULL) dn.blue = d.blue + 8'd1;
        else ph_n = PH_B_DN;
      end
      PH_B_DN: begin
        if (d.blue > DUTY_FLOOR) dn.blue = d.blue - 8'd1;
        else begin
          dn.red   = DUTY_FLOOR;
          dn.green = DUTY_FLOOR;
          ph_n     = PH_RG_UP;
        end
      end
      PH_RG_UP: begin
        if (d.red < DUTY_FULL && d.green < DUTY_FULL) begin
          dn.red   = d.red + 8'd1;
          dn.green = d.green + 8'd1;
        end else ph_n = PH_RG_DN;
      end
      PH_RG_DN: begin
        if (d.red > DUTY_FLOOR && d.green > DUTY_FLOOR) begin
          dn.red   = d.red - 8'd1;
          dn.green = d.green - 8'd1;
        end else begin
          dn.red  = DUTY_FLOOR;
          dn.blue = DUTY_FLOOR;
          ph_n    = PH_RB_UP;
        end
      end
      PH_RB_UP: begin
        if (d.red < DUTY_FULL && d.blue < DUTY_FULL) begin
          dn.red  = d.red + 8'd1;
          dn.blue = d.blue + 8'd1;
        end else ph_n = PH_RB_DN;
      end
      PH_RB_DN: begin
        if (d.red > DUTY_FLOOR && d.blue > DUTY_FLOOR) begin
          dn.red  = d.red - 8'd1;
          dn.blue = d.blue - 8'd1;
        end else begin
          dn.green = DUTY_FLOOR;
          dn.blue  = DUTY_FLOOR;
          ph_n     = PH_GB_UP;
        end
      end
      PH_GB_UP: begin
        if (d.green < DUTY_FULL && d.blue < DUTY_FULL) begin
          dn.green = d.green + 8'd1;
          dn.blue  = d.blue + 8'd1;
        end else ph_n = PH_GB_DN;
      end
      PH_GB_DN: begin
        if (d.green > DUTY_FLOOR && d.blue > DUTY_FLOOR) begin
          dn.green = d.green - 8'd1;
          dn.blue  = d.blue - 8'd1;
        end else begin
          dn.red = DUTY_FLOOR;
          ph_n   = PH_R_UP;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    nxt     = cur;
    updated = 1'b0;
    if (item.func == FUNC_COLOR) begin
      if (!item.color_sel[SEL_W-1]) begin
        nxt.mode = mode_t'(item.color_sel);
        nxt.duty = color_duty(item.color_sel[2:0]);
        updated  = 1'b1;
      end else if (item.color_sel == MODE_BREATH) begin
        nxt.mode      = MODE_BREATH;
        nxt.phase     = PH_R_UP;
        nxt.duty      = '0;
        nxt.last_time = item.timer_now;
      end
      // codes above breathing are dropped
    end else if (cur.mode == MODE_BREATH && diff > threshold) begin
      nxt.last_time = item.timer_now;
      nxt.duty      = dn;
      nxt.phase     = ph_n;
      updated       = 1'b1;
    end
  end

endmodule

[design/rgb_led_color_fade_sequencer_unit.sv]
// RGB LED color fade sequencer, top level: request register, state, result register.
// Depends on rlcfs_pkg, rlcfs_if, rlcfs_cfg and rlcfs_step.
//
// Usage:
//   in_ch  : requests. func = 0 selects a color (0..7 fixed, 8 breathing,
//            9..15 ignored); func = 1 is a timer tick carrying timer_now.
//   out_ch : one result per request: the three duties after the request,
//            the PWM period and the reload flag.
//   cfg_*  : write-only registers, index 0 pwm_period, 1 step_threshold;
//            write only while no request is in flight.
// A request accepted on in_ch passes through the request register, then the
// result register, before its result shows on out_ch.
// Throughput: one request per cycle while out_ch takes results; the state update
// is a single pass of compare and increment logic between the two registers.
// A stalled receiver holds the result register; one further request waits
// in the request register, then in_ch.ready drops until out_ch drains.
// Reset (synchronous, rst_n low): mode off, phase 0, duties 0, step time 0,
// pwm_period 255, step_threshold 16, both channels empty.
module rgb_led_color_fade_sequencer_unit import rlcfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rlcfs_in_if.sink          in_ch,
  rlcfs_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t        cfg;
  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  result_t     out_res_r;
  fade_state_t state_r;
  fade_state_t state_nxt;
  logic        step_upd;
  logic        out_free;
  logic        adv;
  logic        in_acc;

  rlcfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlcfs_step u_step (
    .cur       (state_r),
    .item      (s1_item_r),
    .threshold (cfg.step_threshold),
    .nxt       (state_nxt),
    .updated   (step_upd)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.func      <= in_ch.func;
      s1_item_r.color_sel <= in_ch.color_sel;
      s1_item_r.timer_now <= in_ch.timer_now;
    end
  end

  // sequencer state, updated as each request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode      <= MODE_OFF;
      state_r.phase     <= PH_R_UP;
      state_r.duty      <= '0;
      state_r.last_time <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r.duty    <= state_nxt.duty;
      out_res_r.period  <= cfg.pwm_period;
      out_res_r.updated <= step_upd;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.red_level   = out_res_r.duty.red;
  assign out_ch.green_level = out_res_r.duty.green;
  assign out_ch.blue_level  = out_res_r.duty.blue;
  assign out_ch.period_out  = out_res_r.period;
  assign out_ch.updated     = out_res_r.updated;

  // a tick outside breathing mode never asks for a reload
  a_tick_idle_no_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_item_r.func == FUNC_TICK && state_r.mode != MODE_BREATH)
      |=> (out_valid_r && !out_res_r.updated))
    else $error("tick outside breathing mode reported a reload");

  // a fixed color always asks for a reload
  a_color_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_item_r.func == FUNC_COLOR && !s1_item_r.color_sel[SEL_W-1])
      |=> (out_valid_r && out_res_r.updated))
    else $error("fixed color request did not report a reload");

  // the fade phase moves only in breathing mode
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode != MODE_BREATH)
      |=> (state_r.phase == $past(state_r.phase) || state_r.mode == MODE_BREATH))
    else $error("fade phase changed outside breathing mode");

endmodule

[tb/sv/tb_rgb_led_color_fade_sequencer_unit.sv]
// Self-checking testbench for rgb_led_color_fade_sequencer_unit: directed table plus random
// color, tick and breathing traffic, each result checked against a typed row or an in-bench fade predictor.
// Depends on rlcfs_pkg, rlcfs_if and the DUT sources.
`timescale 1ns / 1ps

module tb_rgb_led_color_fade_sequencer_unit;
  import rlcfs_pkg::*;

  localparam int DIR_N       = 22;
  localparam int HOLD_CYCLES = 60;
  localparam int LAT_PAD     = 6;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    item_t   req;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;

  rlcfs_in_if  in_ch();
  rlcfs_out_if out_ch();

  rgb_led_color_fade_sequencer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [SEL_W-1:0]    m_mode;
  logic [3:0]          m_phase;
  rgb_t                m_duty;
  logic [TIMER_W-1:0]  m_last;
  logic [PERIOD_W-1:0] m_period;
  logic [THRESH_W-1:0] m_thresh;

  result_t  level_q[$];
  dir_row_t dir_tab[DIR_N];

  bit quiet;
  bit hold_req;
  int errors;
  int mismatches;
  int items_sent;
  int results_checked;
  int fade_steps;
  int cfg_writes;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // apply one request to the predictor state and return the expected levels
  task automatic apply_request(input item_t req, output result_t res);
    logic [TIMER_W-1:0] gap;
    logic upd;
    upd = 1'b0;
    gap = m_last - req.timer_now;
    if (req.func == FUNC_COLOR) begin
      if (req.color_sel < MODE_BREATH) begin
        m_mode = req.color_sel;
        case (req.color_sel)
          MODE_RED:    m_duty = '{DUTY_FULL, DUTY_ZERO, DUTY_ZERO};
          MODE_GREEN:  m_duty = '{DUTY_ZERO, DUTY_FULL, DUTY_ZERO};
          MODE_BLUE:   m_duty = '{DUTY_ZERO, DUTY_ZERO, DUTY_FULL};
          MODE_YELLOW: m_duty = '{DUTY_FULL, DUTY_FULL, DUTY_ZERO};
          MODE_PURPLE: m_duty = '{DUTY_FULL, DUTY_ZERO, DUTY_FULL};
          MODE_CYAN:   m_duty = '{DUTY_ZERO, DUTY_FULL, DUTY_FULL};
          MODE_WHITE:  m_duty = '{DUTY_FULL, DUTY_FULL, DUTY_FULL};
          default:     m_duty = '{DUTY_ZERO, DUTY_ZERO, DUTY_ZERO};
        endcase
        upd = 1'b1;
      end else if (req.color_sel == MODE_BREATH) begin
        m_mode  = MODE_BREATH;
        m_phase = PH_R_UP;
        m_duty  = '{DUTY_ZERO, DUTY_ZERO, DUTY_ZERO};
        m_last  = req.timer_now;
      end
    end else if (m_mode == MODE_BREATH && gap > m_thresh) begin
      m_last = req.timer_now;
      upd = 1'b1;
      fade_steps++;
      case (m_phase)
        PH_R_UP:
          if (m_duty.red < DUTY_FULL) m_duty.red++;
          else m_phase = PH_R_DN;
        PH_R_DN:
          if (m_duty.red > DUTY_FLOOR) m_duty.red--;
          else begin
            m_duty.green = DUTY_FLOOR;
            m_phase = PH_G_UP;
          end
        PH_G_UP:
          if (m_duty.green < DUTY_FULL) m_duty.green++;
          else m_phase = PH_G_DN;
        PH_G_DN:
          if (m_duty.green > DUTY_FLOOR) m_duty.green--;
          else begin
            m_duty.blue = DUTY_FLOOR;
            m_phase = PH_B_UP;
          end
        PH_B_UP:
          if (m_duty.blue < DUTY_FULL) m_duty.blue++;
          else m_phase = PH_B_DN;
        PH_B_DN:
          if (m_duty.blue > DUTY_FLOOR) m_duty.blue--;
          else begin
            m_duty.red = DUTY_FLOOR;
            m_duty.green = DUTY_FLOOR;
            m_phase = PH_RG_UP;
          end
        PH_RG_UP:
          if (m_duty.red < DUTY_FULL && m_duty.green < DUTY_FULL) begin
            m_duty.red++;
            m_duty.green++;
          end else m_phase = PH_RG_DN;
        PH_RG_DN:
          if (m_duty.red > DUTY_FLOOR && m_duty.green > DUTY_FLOOR) begin
            m_duty.red--;
            m_duty.green--;
          end else begin
            m_duty.red = DUTY_FLOOR;
            m_duty.blue = DUTY_FLOOR;
            m_phase = PH_RB_UP;
          end
        PH_RB_UP:
          if (m_duty.red < DUTY_FULL && m_duty.blue < DUTY_FULL) begin
            m_duty.red++;
            m_duty.blue++;
          end else m_phase = PH_RB_DN;
        PH_RB_DN:
          if (m_duty.red > DUTY_FLOOR && m_duty.blue > DUTY_FLOOR) begin
            m_duty.red--;
            m_duty.blue--;
          end else begin
            m_duty.green = DUTY_FLOOR;
            m_duty.blue = DUTY_FLOOR;
            m_phase = PH_GB_UP;
          end
        PH_GB_UP:
          if (m_duty.green < DUTY_FULL && m_duty.blue < DUTY_FULL) begin
            m_duty.green++;
            m_duty.blue++;
          end else m_phase = PH_GB_DN;
        PH_GB_DN:
          if (m_duty.green > DUTY_FLOOR && m_duty.blue > DUTY_FLOOR) begin
            m_duty.green--;
            m_duty.blue--;
          end else begin
            m_duty.red = DUTY_FLOOR;
            m_phase = PH_R_UP;
          end
        default: ;  // out-of-range phase: step time reloads, duties hold
      endcase
    end
    res.duty    = m_duty;
    res.period  = m_period;
    res.updated = upd;
  endtask

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_item(input item_t req, input bit typed, input result_t want);
    result_t pred;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= req.func;
    in_ch.color_sel <= req.color_sel;
    in_ch.timer_now <= req.timer_now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_request(req, pred);
    level_q.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [PERIOD_W-1:0] period, input logic [THRESH_W-1:0] thresh);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PWM_PERIOD;
    cfg_wdata <= CFG_DW'(period);
    @(posedge clk);
    m_period = period;
    @(negedge clk);
    cfg_addr  <= CFG_STEP_THRESHOLD;
    cfg_wdata <= thresh;
    @(posedge clk);
    m_thresh = thresh;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes += 2;
  endtask

  // stop offering, wait for all results plus pipeline slack
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_mixed(input int n);
    item_t req;
    for (int i = 0; i < n; i++) begin
      req.func      = ($urandom_range(0, 9) < 6) ? FUNC_TICK : FUNC_COLOR;
      req.color_sel = ($urandom_range(0, 3) == 0) ? MODE_BREATH : SEL_W'($urandom_range(0, 15));
      req.timer_now = TIMER_W'($urandom_range(0, 65535));
      send_item(req, 1'b0, '0);
    end
  endtask

  // enter breathing, then mostly ticks that are due so the fade walks through its phases
  task automatic run_fade(input int n);
    item_t req;
    int k;
    req.func      = FUNC_COLOR;
    req.color_sel = MODE_BREATH;
    req.timer_now = TIMER_W'($urandom_range(0, 65535));
    send_item(req, 1'b0, '0);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      req.func      = FUNC_TICK;
      req.color_sel = SEL_W'($urandom_range(0, 15));
      if (k < 85) begin
        req.timer_now = m_last - m_thresh - TIMER_W'(1 + $urandom_range(0, 40));
      end else if (k < 93) begin
        req.timer_now = m_last - TIMER_W'($urandom_range(0, int'(m_thresh)));
      end else if (k < 97) begin
        req.func      = FUNC_COLOR;
        req.color_sel = SEL_W'($urandom_range(9, 15));
        req.timer_now = TIMER_W'($urandom_range(0, 65535));
      end else begin
        req.timer_now = TIMER_W'($urandom_range(0, 65535));
      end
      send_item(req, 1'b0, '0);
    end
  endtask

  // result sink: random back-pressure bursts, plus one long hold-off on request
  initial begin : result_sink
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (level_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing pending: r=%0d g=%0d b=%0d p=%0d u=%0b", $time,
                   out_ch.red_level, out_ch.green_level, out_ch.blue_level,
                   out_ch.period_out, out_ch.updated);
      end else begin
        want = level_q.pop_front();
        results_checked++;
        if (out_ch.red_level !== want.duty.red || out_ch.green_level !== want.duty.green ||
            out_ch.blue_level !== want.duty.blue || out_ch.period_out !== want.period ||
            out_ch.updated !== want.updated) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: exp r=%0d g=%0d b=%0d p=%0d u=%0b got r=%0d g=%0d b=%0d p=%0d u=%0b",
                     $time, want.duty.red, want.duty.green, want.duty.blue, want.period,
                     want.updated, out_ch.red_level, out_ch.green_level, out_ch.blue_level,
                     out_ch.period_out, out_ch.updated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending", idle_cycles,
                 level_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : main_seq
    // directed rows: typed expectations for reset, fixed colors, ignored codes and breathing entry
    dir_tab[0]  = '{'{FUNC_TICK,  MODE_OFF,    16'h0000}, 1'b1,
                    '{'{DUTY_ZERO, DUTY_ZERO, DUTY_ZERO}, PERIOD_RST, 1'b0}};
    dir_tab[1]  = '{'{FUNC_COLOR, MODE_OFF,    16'hFFFF}, 1'b1,
                    '{'{DUTY_ZERO, DUTY_ZERO, DUTY_ZERO}, PERIOD_RST, 1'b1}};
    dir_tab[2]  = '{'{FUNC_COLOR, MODE_RED,    16'h0000}, 1'b1,
                    '{'{DUTY_FULL, DUTY_ZERO, DUTY_ZERO}, PERIOD_RST, 1'b1}};
    dir_tab[3]  = '{'{FUNC_COLOR, MODE_GREEN,  16'h1234}, 1'b1,
                    '{'{DUTY_ZERO, DUTY_FULL, DUTY_ZERO}, PERIOD_RST, 1'b1}};
    dir_tab[4]  = '{'{FUNC_COLOR, MODE_BLUE,   16'h5555}, 1'b1,
                    '{'{DUTY_ZERO, DUTY_ZERO, DUTY_FULL}, PERIOD_RST, 1'b1}};
    dir_tab[5]  = '{'{FUNC_COLOR, MODE_YELLOW, 16'hAAAA}, 1'b1,
                    '{'{DUTY_FULL, DUTY_FULL, DUTY_ZERO}, PERIOD_RST, 1'b1}};
    dir_tab[6]  = '{'{FUNC_COLOR, MODE_PURPLE, 16'h8000}, 1'b1,
                    '{'{DUTY_FULL, DUTY_ZERO, DUTY_FULL}, PERIOD_RST, 1'b1}};
    dir_tab[7]  = '{'{FUNC_COLOR, MODE_CYAN,   16'h7FFF}, 1'b1,
                    '{'{DUTY_ZERO, DUTY_FULL, DUTY_FULL}, PERIOD_RST, 1'b1}};
    dir_tab[8]  = '{'{FUNC_COLOR, MODE_WHITE,  16'hFFFF}, 1'b1,
                    '{'{DUTY_FULL, DUTY_FULL, DUTY_FULL}, PERIOD_RST, 1'b1}};
    // undefined color codes and ticks outside breathing leave white in place; breathing entry clears it
    dir_tab[9]  = '{'{FUNC_COLOR, 4'd9,        16'h0000}, 1'b1,
                    '{'{DUTY_FULL, DUTY_FULL, DUTY_FULL}, PERIOD_RST, 1'b0}};
    dir_tab[10] = '{'{FUNC_COLOR, 4'd15,       16'hFFFF}, 1'b1,
                    '{'{DUTY_FULL, DUTY_FULL, DUTY_FULL}, PERIOD_RST, 1'b0}};
    dir_tab[11] = '{'{FUNC_TICK,  4'd15,       16'hFFFF}, 1'b1,
                    '{'{DUTY_FULL, DUTY_FULL, DUTY_FULL}, PERIOD_RST, 1'b0}};
    dir_tab[12] = '{'{FUNC_COLOR, MODE_BREATH, 16'h0000}, 1'b1,
                    '{'{DUTY_ZERO, DUTY_ZERO, DUTY_ZERO}, PERIOD_RST, 1'b0}};
    // threshold edges around 16, then a wrapped difference
    dir_tab[13] = '{'{FUNC_TICK,  MODE_OFF,    16'h0000}, 1'b0, '0};
    dir_tab[14] = '{'{FUNC_TICK,  MODE_OFF,    16'hFFFF}, 1'b0, '0};
    dir_tab[15] = '{'{FUNC_TICK,  MODE_OFF,    16'hFFEF}, 1'b0, '0};
    dir_tab[16] = '{'{FUNC_TICK,  MODE_OFF,    16'hFFDF}, 1'b0, '0};
    dir_tab[17] = '{'{FUNC_TICK,  MODE_OFF,    16'hFFDE}, 1'b0, '0};
    dir_tab[18] = '{'{FUNC_TICK,  MODE_WHITE,  16'h0010}, 1'b0, '0};
    dir_tab[19] = '{'{FUNC_TICK,  MODE_BREATH, 16'h0010}, 1'b0, '0};
    dir_tab[20] = '{'{FUNC_COLOR, MODE_BREATH, 16'h8000}, 1'b0, '0};
    dir_tab[21] = '{'{FUNC_TICK,  4'd12,       16'h7FEF}, 1'b0, '0};

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = CFG_PWM_PERIOD;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_COLOR;
    in_ch.color_sel = MODE_OFF;
    in_ch.timer_now = '0;
    out_ch.ready    = 1'b0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    errors          = 0;
    mismatches      = 0;
    items_sent      = 0;
    results_checked = 0;
    fade_steps      = 0;
    cfg_writes      = 0;
    idle_cycles     = 0;
    m_mode   = MODE_OFF;
    m_phase  = PH_R_UP;
    m_duty   = '{DUTY_ZERO, DUTY_ZERO, DUTY_ZERO};
    m_last   = '0;
    m_period = PERIOD_RST;
    m_thresh = THRESH_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++) send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
    settle();

    // zero threshold: any timer change steps the fade
    write_cfg(8'd0, 16'd0);
    hold_req = 1'b1;
    run_mixed(200);
    settle();

    // max threshold: no difference can exceed it
    write_cfg(8'd255, 16'hFFFF);
    run_mixed(100);
    settle();

    write_cfg(PERIOD_W'($urandom_range(0, 255)), THRESH_W'($urandom_range(0, 65535)));
    run_mixed(150);
    settle();

    write_cfg(PERIOD_W'($urandom_range(1, 254)), THRESH_W'($urandom_range(0, 8)));
    hold_req = 1'b1;
    run_fade(1000);
    settle();

    // closing stretch at full rate, no idling on either side
    quiet = 1'b1;
    write_cfg(8'd128, 16'd2);
    run_fade(120);
    settle();

    if (level_q.size() != 0) begin
      errors += level_q.size();
      $display("%0d expected results never arrived", level_q.size());
    end
    $display("Covered %0d requests and %0d results: fixed colors, ignored codes, breathing",
             items_sent, results_checked);
    $display("with %0d fade steps and %0d register writes, thresholds 0 to 65535",
             fade_steps, cfg_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d errors", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[rgb_led_color_fade_sequencer_unit.f]
design/rlcfs_pkg.sv
design/rlcfs_if.sv
design/rlcfs_cfg.sv
design/rlcfs_step.sv
design/rgb_led_color_fade_sequencer_unit.sv
tb/sv/tb_rgb_led_color_fade_sequencer_unit.sv
